[rtl/tlap_pkg.sv]
// shared types and constants for the application list parser
// no dependencies
package tlap_pkg;

    // tag and length-form bytes
    localparam logic [7:0] TAG_TEMPLATE = 8'h61;
    localparam logic [7:0] TAG_AID      = 8'h4F;
    localparam logic [7:0] TAG_PRIO     = 8'h87;
    localparam logic [7:0] LEN_ONE      = 8'h81;
    localparam logic [7:0] LEN_TWO      = 8'h82;

    // result kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_AID   = 2'd1;
    localparam logic [1:0] KIND_PRIO  = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // element kinds
    localparam logic [1:0] EK_NONE = 2'd0;
    localparam logic [1:0] EK_AID  = 2'd1;
    localparam logic [1:0] EK_PRIO = 2'd2;

    localparam int QUEUE_DEPTH_DEF = 4;

    // one result on the output channel
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  app_number;
        logic [15:0] byte_position;
        logic [7:0]  item_value;
        logic [15:0] aid_length;
        logic        final_flag;
    } result_t;

    // what one accepted item produced: an optional byte result and an optional end result
    typedef struct packed {
        logic        has_byte;
        logic [1:0]  kind;
        logic [7:0]  app_number;
        logic [15:0] byte_position;
        logic [7:0]  item_value;
        logic [15:0] aid_length;
        logic        has_end;
        logic [7:0]  app_count;
    } entry_t;

endpackage

[rtl/tlap_front.sv]
// front part: accepts response bytes, runs the tlv parse state, builds queue entries
// depends on tlap_pkg
module tlap_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [7:0]      s_data_byte,
    input  logic            s_end_of_response,
    input  logic            q_full,
    output logic            q_push,
    output tlap_pkg::entry_t q_entry
);
    import tlap_pkg::*;

    typedef enum logic [4:0] {
        PH_SCAN   = 5'b00001,
        PH_TLEN   = 5'b00010,
        PH_INSIDE = 5'b00100,
        PH_ELEN   = 5'b01000,
        PH_EVAL   = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [1:0]  ekind_reg, ekind_next;
    logic [1:0]  lbl_reg, lbl_next;
    logic [15:0] elen_reg, elen_next;
    logic [15:0] erem_reg, erem_next;
    logic [15:0] trem_reg, trem_next;
    logic [7:0]  acnt_reg, acnt_next;
    logic [15:0] vpos_reg, vpos_next;

    logic        accept;
    logic [15:0] trem_dec;
    logic [15:0] erem_dec;
    logic [15:0] acc_src;
    logic [15:0] feed_acc;
    logic [1:0]  feed_lbl;
    logic        feed_done;
    logic [7:0]  cur_app;
    entry_t      ent;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    assign trem_dec = (trem_reg != 16'd0) ? trem_reg - 16'd1 : 16'd0;
    assign erem_dec = (erem_reg != 16'd0) ? erem_reg - 16'd1 : 16'd0;
    assign cur_app  = (acnt_reg == 8'd0) ? 8'd0 : acnt_reg - 8'd1;

    // length decoding, short or long form
    always_comb begin
        acc_src = (phase_reg == PH_TLEN) ? trem_reg : elen_reg;
        if (lbl_reg == 2'd0) begin
            if (s_data_byte == LEN_ONE) begin
                feed_acc  = 16'd0;
                feed_lbl  = 2'd1;
                feed_done = 1'b0;
            end else if (s_data_byte == LEN_TWO) begin
                feed_acc  = 16'd0;
                feed_lbl  = 2'd2;
                feed_done = 1'b0;
            end else begin
                feed_acc  = {8'd0, s_data_byte};
                feed_lbl  = 2'd0;
                feed_done = 1'b1;
            end
        end else begin
            feed_acc  = {acc_src[7:0], s_data_byte};
            feed_lbl  = lbl_reg - 2'd1;
            feed_done = (lbl_reg == 2'd1);
        end
    end

    always_comb begin
        phase_next = phase_reg;
        ekind_next = ekind_reg;
        lbl_next   = lbl_reg;
        elen_next  = elen_reg;
        erem_next  = erem_reg;
        trem_next  = trem_reg;
        acnt_next  = acnt_reg;
        vpos_next  = vpos_reg;
        ent        = '0;

        unique case (phase_reg)
            PH_TLEN: begin
                trem_next = feed_acc;
                lbl_next  = feed_lbl;
                if (feed_done) begin
                    ent.has_byte   = 1'b1;
                    ent.kind       = KIND_START;
                    ent.app_number = acnt_reg;
                    if (acnt_reg != 8'hFF) begin
                        acnt_next = acnt_reg + 8'd1;
                    end
                    phase_next = (feed_acc == 16'd0) ? PH_SCAN : PH_INSIDE;
                end
            end
            PH_INSIDE: begin
                trem_next = trem_dec;
                if (s_data_byte == TAG_AID || s_data_byte == TAG_PRIO) begin
                    ekind_next = (s_data_byte == TAG_AID) ? EK_AID : EK_PRIO;
                    lbl_next   = 2'd0;
                    elen_next  = 16'd0;
                    phase_next = PH_ELEN;
                end else if (trem_dec == 16'd0) begin
                    phase_next = PH_SCAN;
                end
            end
            PH_ELEN: begin
                trem_next = trem_dec;
                elen_next = feed_acc;
                lbl_next  = feed_lbl;
                if (feed_done) begin
                    erem_next = feed_acc;
                    vpos_next = 16'd0;
                    if (feed_acc == 16'd0) begin
                        ekind_next = EK_NONE;
                        phase_next = (trem_dec == 16'd0) ? PH_SCAN : PH_INSIDE;
                    end else begin
                        phase_next = PH_EVAL;
                    end
                end
            end
            PH_EVAL: begin
                trem_next = trem_dec;
                erem_next = erem_dec;
                vpos_next = vpos_reg + 16'd1;
                if (ekind_reg == EK_AID) begin
                    ent.has_byte      = 1'b1;
                    ent.kind          = KIND_AID;
                    ent.app_number    = cur_app;
                    ent.byte_position = vpos_reg;
                    ent.item_value    = s_data_byte;
                    ent.aid_length    = elen_reg;
                end
                if (erem_dec == 16'd0) begin
                    if (ekind_reg == EK_PRIO) begin
                        ent.has_byte   = 1'b1;
                        ent.kind       = KIND_PRIO;
                        ent.app_number = cur_app;
                        ent.item_value = s_data_byte;
                    end
                    ekind_next = EK_NONE;
                    phase_next = (trem_dec == 16'd0) ? PH_SCAN : PH_INSIDE;
                end
            end
            default: begin
                if (s_data_byte == TAG_TEMPLATE) begin
                    lbl_next   = 2'd0;
                    trem_next  = 16'd0;
                    phase_next = PH_TLEN;
                end else begin
                    phase_next = PH_SCAN;
                end
            end
        endcase

        ent.has_end   = s_end_of_response;
        ent.app_count = acnt_next;
    end

    assign q_entry = ent;
    assign q_push  = accept && (ent.has_byte || ent.has_end);

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_end_of_response)) begin
            phase_reg <= PH_SCAN;
            ekind_reg <= EK_NONE;
            lbl_reg   <= 2'd0;
            elen_reg  <= 16'd0;
            erem_reg  <= 16'd0;
            trem_reg  <= 16'd0;
            acnt_reg  <= 8'd0;
            vpos_reg  <= 16'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            ekind_reg <= ekind_next;
            lbl_reg   <= lbl_next;
            elen_reg  <= elen_next;
            erem_reg  <= erem_next;
            trem_reg  <= trem_next;
            acnt_reg  <= acnt_next;
            vpos_reg  <= vpos_next;
        end
    end

endmodule

[rtl/tlap_queue.sv]
// short queue of parsed entries between front and back
// depends on tlap_pkg
module tlap_queue #(
    parameter int DEPTH = tlap_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  tlap_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output tlap_pkg::entry_t head,
    output logic             empty
);
    import tlap_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULLC = CW'(DEPTH);

    entry_t          slot_reg [DEPTH];
    logic [PW-1:0]   wptr_reg, rptr_reg;
    logic [CW-1:0]   cnt_reg;
    logic            do_push, do_pop;

    assign full    = (cnt_reg == FULLC);
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= (wptr_reg == LAST) ? '0 : wptr_reg + PW'(1);
            end
            if (do_pop) begin
                rptr_reg <= (rptr_reg == LAST) ? '0 : rptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

endmodule

[rtl/tlap_back.sv]
// back part: splits queue entries into results and drives the output register
// depends on tlap_pkg
module tlap_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  tlap_pkg::entry_t head,
    input  logic             q_empty,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output tlap_pkg::result_t m_res
);
    import tlap_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    sub_done_reg, sub_done_next;
    logic    load, take, first_part;

    assign load       = !out_valid_reg || m_ready;
    assign take       = load && !q_empty;
    assign first_part = head.has_byte && !sub_done_reg;

    always_comb begin
        out_next       = out_reg;
        sub_done_next  = sub_done_reg;
        out_valid_next = load ? 1'b0 : out_valid_reg;
        q_pop          = 1'b0;
        if (take) begin
            out_valid_next = 1'b1;
            if (first_part) begin
                out_next.kind          = head.kind;
                out_next.app_number    = head.app_number;
                out_next.byte_position = head.byte_position;
                out_next.item_value    = head.item_value;
                out_next.aid_length    = head.aid_length;
                out_next.final_flag    = !head.has_end;
                sub_done_next          = head.has_end;
                q_pop                  = !head.has_end;
            end else begin
                // end-of-response result with the application count
                out_next.kind          = KIND_END;
                out_next.app_number    = 8'd0;
                out_next.byte_position = 16'd0;
                out_next.item_value    = head.app_count;
                out_next.aid_length    = 16'd0;
                out_next.final_flag    = 1'b1;
                sub_done_next          = 1'b0;
                q_pop                  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            sub_done_reg  <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            sub_done_reg  <= sub_done_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

endmodule

[rtl/tlv_application_list_parser_top.sv]
// top level of the application list parser: front, queue and back
// depends on tlap_pkg, tlap_front, tlap_queue, tlap_back
//
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+-----------------------------------------
// s_        | in        | s_valid / s_ready  | s_data_byte, s_end_of_response
// m_        | out       | m_valid / m_ready  | m_kind, m_app_number, m_byte_position,
//           |           |                    | m_item_value, m_aid_length, m_final_flag
//
// the front takes one byte per cycle while the queue is not full; the parse state updates in that same cycle
// the output register gives one result per cycle while m_ready allows, so a byte that ends the response
// and also yields a result needs two output results in turn; the queue absorbs that
// s_ready drops only while the QUEUE_DEPTH-entry queue is full
// aresetn is synchronous and active low; it clears the parse state, the queue and
// the output valid, with no clearing pass
module tlv_application_list_parser_top #(
    parameter int QUEUE_DEPTH = tlap_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_response,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [7:0]  m_app_number,
    output logic [15:0] m_byte_position,
    output logic [7:0]  m_item_value,
    output logic [15:0] m_aid_length,
    output logic        m_final_flag
);
    import tlap_pkg::*;

    // front to queue
    logic    q_push;
    entry_t  q_in;
    logic    q_full;

    // queue to back
    entry_t  q_head;
    logic    q_empty;
    logic    q_pop;

    result_t res;

    // parser: classifies each byte and updates the tlv state
    tlap_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_response (s_end_of_response),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_entry           (q_in)
    );

    // decouples parsing from output stalls
    tlap_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty)
    );

    // emits byte result then end result, one per cycle while the output is not stalled
    tlap_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (q_head),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (res)
    );

    assign m_kind          = res.kind;
    assign m_app_number    = res.app_number;
    assign m_byte_position = res.byte_position;
    assign m_item_value    = res.item_value;
    assign m_aid_length    = res.aid_length;
    assign m_final_flag    = res.final_flag;

endmodule

[verif/tb_tlv_application_list_parser_top.sv]
`timescale 1ns / 100ps
// self-checking bench for the application list parser: random card responses in, results checked
// depends on tlap_pkg and tlv_application_list_parser_top
module tb_tlv_application_list_parser_top;
    import tlap_pkg::*;

    // parse phases of the predictor
    typedef enum logic [2:0] {
        PH_SCAN,
        PH_TLEN,
        PH_INSIDE,
        PH_ELEN,
        PH_EVAL
    } parse_phase_t;

    // predicts the results of each accepted byte and checks the results in order
    class app_list_scoreboard;
        parse_phase_t phase;
        logic [1:0]   elem_kind;
        logic [1:0]   len_left;
        logic [15:0]  elem_len;
        logic [15:0]  elem_left;
        logic [15:0]  tmpl_left;
        logic [7:0]   app_count;
        logic [15:0]  value_pos;
        result_t      awaited_results[$];
        int           errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            phase     = PH_SCAN;
            elem_kind = EK_NONE;
            len_left  = 2'd0;
            elem_len  = 16'd0;
            elem_left = 16'd0;
            tmpl_left = 16'd0;
            app_count = 8'd0;
            value_pos = 16'd0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void push_result(logic [1:0] kind, logic [7:0] app, logic [15:0] pos,
                                  logic [7:0] val, logic [15:0] alen);
            result_t r;
            r.kind          = kind;
            r.app_number    = app;
            r.byte_position = pos;
            r.item_value    = val;
            r.aid_length    = alen;
            r.final_flag    = 1'b0;
            awaited_results.push_back(r);
        endfunction

        // one length byte; returns 1 once the length is complete
        function bit feed_length(input logic [7:0] b, inout logic [15:0] acc);
            bit done;
            done = 1'b0;
            if (len_left == 2'd0) begin
                if (b == LEN_ONE) begin
                    len_left = 2'd1;
                    acc = 16'd0;
                end else if (b == LEN_TWO) begin
                    len_left = 2'd2;
                    acc = 16'd0;
                end else begin
                    acc = {8'h00, b};
                    done = 1'b1;
                end
            end else begin
                acc = {acc[7:0], b};
                len_left = len_left - 2'd1;
                done = (len_left == 2'd0);
            end
            return done;
        endfunction

        function void end_element();
            elem_kind = EK_NONE;
            phase = (tmpl_left == 16'd0) ? PH_SCAN : PH_INSIDE;
        endfunction

        function void count_template_byte();
            if (tmpl_left != 16'd0)
                tmpl_left = tmpl_left - 16'd1;
        endfunction

        // accepted input item: work out the results it causes
        function void parse_byte(logic [7:0] b, logic eor);
            int         size_before;
            logic [7:0] cur;
            size_before = awaited_results.size();
            cur = (app_count == 8'd0) ? 8'd0 : app_count - 8'd1;
            case (phase)
                PH_TLEN: begin
                    if (feed_length(b, tmpl_left)) begin
                        push_result(KIND_START, app_count, 16'd0, 8'd0, 16'd0);
                        if (app_count != 8'hFF)
                            app_count = app_count + 8'd1;
                        phase = (tmpl_left == 16'd0) ? PH_SCAN : PH_INSIDE;
                    end
                end
                PH_INSIDE: begin
                    count_template_byte();
                    if (b == TAG_AID || b == TAG_PRIO) begin
                        elem_kind = (b == TAG_AID) ? EK_AID : EK_PRIO;
                        len_left  = 2'd0;
                        elem_len  = 16'd0;
                        phase     = PH_ELEN;
                    end else if (tmpl_left == 16'd0) begin
                        phase = PH_SCAN;
                    end
                end
                PH_ELEN: begin
                    count_template_byte();
                    if (feed_length(b, elem_len)) begin
                        elem_left = elem_len;
                        value_pos = 16'd0;
                        if (elem_len == 16'd0)
                            end_element();
                        else
                            phase = PH_EVAL;
                    end
                end
                PH_EVAL: begin
                    count_template_byte();
                    if (elem_kind == EK_AID)
                        push_result(KIND_AID, cur, value_pos, b, elem_len);
                    value_pos = value_pos + 16'd1;
                    if (elem_left != 16'd0)
                        elem_left = elem_left - 16'd1;
                    if (elem_left == 16'd0) begin
                        if (elem_kind == EK_PRIO)
                            push_result(KIND_PRIO, cur, 16'd0, b, 16'd0);
                        end_element();
                    end
                end
                default: begin
                    if (b == TAG_TEMPLATE) begin
                        len_left  = 2'd0;
                        tmpl_left = 16'd0;
                        phase     = PH_TLEN;
                    end else begin
                        phase = PH_SCAN;
                    end
                end
            endcase
            if (eor) begin
                push_result(KIND_END, 8'd0, 16'd0, app_count, 16'd0);
                clear_state();
            end
            if (awaited_results.size() > size_before)
                awaited_results[awaited_results.size() - 1].final_flag = 1'b1;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        // accepted result: compare with the oldest awaited one
        function void check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0) begin
                $error("unexpected result: kind %0d item_value %0d", got.kind, got.item_value);
                errors++;
            end else begin
                want = awaited_results.pop_front();
                compare_field("kind", want.kind, got.kind);
                compare_field("app_number", want.app_number, got.app_number);
                compare_field("byte_position", want.byte_position, got.byte_position);
                compare_field("item_value", want.item_value, got.item_value);
                compare_field("aid_length", want.aid_length, got.aid_length);
                compare_field("final_flag", want.final_flag, got.final_flag);
            end
        endfunction
    endclass

    // every input known from time zero
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data_byte = 8'h00;
    logic        s_end_of_response = 1'b0;
    logic        m_ready = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [1:0]  m_kind;
    logic [7:0]  m_app_number;
    logic [15:0] m_byte_position;
    logic [7:0]  m_item_value;
    logic [15:0] m_aid_length;
    logic        m_final_flag;

    // idling odds in percent, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned bytes_sent = 0;

    // response being built before it is sent
    logic [7:0] resp_q[$];

    app_list_scoreboard sb = new();

    tlv_application_list_parser_top u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_data_byte       (s_data_byte),
        .s_end_of_response (s_end_of_response),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_kind            (m_kind),
        .m_app_number      (m_app_number),
        .m_byte_position   (m_byte_position),
        .m_item_value      (m_item_value),
        .m_aid_length      (m_aid_length),
        .m_final_flag      (m_final_flag)
    );

    always #5 aclk = ~aclk;

    // result side: stall at random, one assignment per edge
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // both handshakes sampled at the edge; the input is noted before any result is checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.parse_byte(s_data_byte, s_end_of_response);
            if (m_valid && m_ready)
                sb.check_result('{kind: m_kind, app_number: m_app_number,
                                  byte_position: m_byte_position, item_value: m_item_value,
                                  aid_length: m_aid_length, final_flag: m_final_flag});
        end
    end

    // one item on the input side, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic eor);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_data_byte       <= b;
        s_end_of_response <= eor;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // send the built response; the last byte carries end of response
    task automatic send_response();
        for (int i = 0; i < resp_q.size(); i++)
            send_byte(resp_q[i], i == resp_q.size() - 1);
    endtask

    // length field in a random legal form; long form forced above one byte
    function automatic void push_length(ref logic [7:0] q[$], input logic [15:0] len);
        int unsigned form;
        form = $urandom_range(2);
        if (len > 16'd255)
            form = 2;
        else if (form == 0 && (len[7:0] == LEN_ONE || len[7:0] == LEN_TWO))
            form = 1;
        case (form)
            0: q.push_back(len[7:0]);
            1: begin
                q.push_back(LEN_ONE);
                q.push_back(len[7:0]);
            end
            default: begin
                q.push_back(LEN_TWO);
                q.push_back(len[15:8]);
                q.push_back(len[7:0]);
            end
        endcase
    endfunction

    // one template: aid and priority elements mixed with other tags and stray bytes
    function automatic void push_template(ref logic [7:0] q[$]);
        logic [7:0]  body[$];
        logic [7:0]  other_tags[4];
        logic [15:0] len;
        int unsigned sel;
        other_tags = '{8'h50, 8'h9F, 8'h5F, 8'h73};
        for (int e = $urandom_range(4); e > 0; e--) begin
            sel = $urandom_range(19);
            if (sel < 9) begin
                // aid, now and then empty
                body.push_back(TAG_AID);
                len = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(16, 1));
                push_length(body, len);
                for (int i = 0; i < len; i++)
                    body.push_back(8'($urandom_range(255)));
            end else if (sel < 14) begin
                body.push_back(TAG_PRIO);
                len = 16'($urandom_range(2));
                push_length(body, len);
                for (int i = 0; i < len; i++)
                    body.push_back(8'($urandom_range(255)));
            end else if (sel == 14) begin
                // aid declaring a long value; it swallows what follows
                body.push_back(TAG_AID);
                push_length(body, 16'($urandom_range(65535, 256)));
                for (int i = $urandom_range(6); i > 0; i--)
                    body.push_back(8'($urandom_range(255)));
            end else if (sel < 18) begin
                body.push_back(other_tags[$urandom_range(3)]);
                len = 16'($urandom_range(4));
                push_length(body, len);
                for (int i = 0; i < len; i++)
                    body.push_back(8'($urandom_range(255)));
            end else begin
                body.push_back(8'($urandom_range(255)));
            end
        end
        len = 16'(body.size());
        // now and then a template length that is off against its content
        if ($urandom_range(7) == 0)
            len = (len > 16'd3 && $urandom_range(1)) ? len - 16'($urandom_range(3, 1))
                                                      : len + 16'($urandom_range(3, 1));
        q.push_back(TAG_TEMPLATE);
        push_length(q, len);
        foreach (body[i])
            q.push_back(body[i]);
    endfunction

    // mostly well formed responses, some noise and some cut short
    function automatic void build_response();
        resp_q.delete();
        if ($urandom_range(9) == 0) begin
            for (int i = $urandom_range(8, 1); i > 0; i--)
                resp_q.push_back(8'($urandom_range(255)));
        end else begin
            for (int i = $urandom_range(2); i > 0; i--)
                resp_q.push_back(8'($urandom_range(255)));
            for (int t = $urandom_range(3, 1); t > 0; t--)
                push_template(resp_q);
            if ($urandom_range(1))
                resp_q.push_back(8'($urandom_range(255)));
        end
        if ($urandom_range(5) == 0 && resp_q.size() > 1)
            resp_q = resp_q[0:$urandom_range(resp_q.size() - 2)];
    endfunction

    // enough empty templates to drive the application count past saturation
    function automatic void build_saturating_response();
        resp_q.delete();
        for (int i = 0; i < 258; i++) begin
            resp_q.push_back(TAG_TEMPLATE);
            resp_q.push_back(8'h00);
        end
        resp_q.push_back(8'h00);
    endfunction

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: noise extremes, two-byte template length, aid, priority,
        // empty element, plain byte ending the response
        resp_q = '{8'hFF, TAG_TEMPLATE, LEN_TWO, 8'h00, 8'h09,
                   TAG_AID, 8'h02, 8'hA0, 8'h00,
                   TAG_PRIO, 8'h01, 8'h05,
                   TAG_AID, 8'h00,
                   8'h00};
        send_response();
        // directed: empty template, one-byte length form, element overrunning
        // its template, response ending mid-element
        resp_q = '{TAG_TEMPLATE, 8'h00,
                   TAG_TEMPLATE, LEN_ONE, 8'h02, TAG_AID, 8'h05, 8'hAA, 8'h55};
        send_response();

        // random phases: no idling, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 81 : (ph == 3) ? 18 : 0;
            recv_stall_pct = (ph == 2) ? 81 : (ph == 3) ? 18 : 0;
            if (ph == 0) begin
                build_saturating_response();
                send_response();
            end
            while (bytes_sent < 24 + (ph + 1) * 350) begin
                build_response();
                send_response();
            end
        end
        s_valid <= 1'b0;

        // drain, then let the pipeline settle
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule

[tlv_application_list_parser_top.f]
rtl/tlap_pkg.sv
rtl/tlap_front.sv
rtl/tlap_queue.sv
rtl/tlap_back.sv
rtl/tlv_application_list_parser_top.sv
verif/tb_tlv_application_list_parser_top.sv
